// ===== sv/sdspi_pkg.sv =====
// package: phase codes, commands, status codes and payload structs
`default_nettype none
package sdspi_pkg;

   typedef enum logic [4:0] {
      PH_IDLE, PH_WAKE, PH_CMD0, PH_CMD0_DUM, PH_CMD8, PH_CMD8_TRAIL, PH_CMD8_DUM,
      PH_CMD55, PH_CMD55_DUM, PH_ACMD41, PH_ACMD41_DUM, PH_CMD16, PH_CMD16_DUM,
      PH_CMD24, PH_CMD24_DUM, PH_GAP, PH_TOKEN, PH_DATA_WAIT, PH_DATA_XFER, PH_CRC,
      PH_RESP, PH_RESP_DUM, PH_BUSY_XFER, PH_BUSY_WAIT, PH_FINAL_DUM
   } phase_type;

   localparam logic [2:0] CMD_INIT  = 3'd0;
   localparam logic [2:0] CMD_WRITE = 3'd1;
   localparam logic [2:0] CMD_DONE  = 3'd2;
   localparam logic [2:0] CMD_DATA  = 3'd3;
   localparam logic [2:0] CMD_TICK  = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_IDLE  = 3'd1;
   localparam logic [2:0] ST_INIT_TO   = 3'd2;
   localparam logic [2:0] ST_BLEN_REJ  = 3'd3;
   localparam logic [2:0] ST_CMD_REJ   = 3'd4;
   localparam logic [2:0] ST_DATA_REJ  = 3'd5;
   localparam logic [2:0] ST_BUSY_TO   = 3'd6;

   localparam logic [1:0] REG_WAKE  = 2'd0;
   localparam logic [1:0] REG_RESP  = 2'd1;
   localparam logic [1:0] REG_RETRY = 2'd2;
   localparam logic [1:0] REG_BUSY  = 2'd3;

   localparam logic [2:0] POLLING_R1 = 3'd6;
   localparam logic [7:0] BYTE_IDLE  = 8'hFF;
   localparam logic [7:0] TOKEN      = 8'hFE;
   localparam logic [9:0] BLOCK_BYTES = 10'd512;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] sector_address;
      logic [7:0]  rx_byte;
      logic [7:0]  data_value;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       select_asserted;
      logic       data_request;
      logic       done_res;
      logic [2:0] status;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/sdspi_if.sv =====
// valid/ready channel interface carrying one payload struct
`default_nettype none
interface sdspi_req_if;
   logic valid;
   logic ready;
   sdspi_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sdspi_rsp_if;
   logic valid;
   logic ready;
   sdspi_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/sd_spi_init_and_block_write.sv =====
// top level: sd card spi-mode init and single block write sequencer
// a result is written into the output buffer when its transaction is accepted
// throughput: one input transaction per cycle while the buffer is not full; the
// output register is a two-entry buffer so input keeps flowing while a result waits
// reset: synchronous active high, sequencer idle, registers at defaults
`default_nettype none
module sd_spi_init_and_block_write (
   input  wire          clock,
   input  wire          reset,
   sdspi_req_if.sink    req,
   sdspi_rsp_if.source  rsp,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire [3:0]    csr_paddr,
   input  wire [31:0]   csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   sdspi_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  fidx_ff, fidx_in;
   logic [9:0]  bcnt_ff, bcnt_in;
   logic [7:0]  poll_ff, poll_in;
   logic [15:0] retry_ff, retry_in;
   logic [7:0]  last_ff, last_in;
   logic [31:0] sector_ff, sector_in;
   logic [7:0]  wake_ff, rlim_ff, blim_ff;
   logic [15:0] ilim_ff;

   // two-entry result buffer
   sdspi_pkg::rsp_type buf_ff [2];
   logic [1:0] cnt_ff;
   logic       rd_ff, wr_ff;

   sdspi_pkg::rsp_type r;
   logic emit;
   logic acc;
   sdspi_pkg::req_type q;

   assign q = req.data;
   assign req.ready = (cnt_ff != 2'd2);
   assign acc = req.valid && req.ready;
   assign rsp.valid = (cnt_ff != 2'd0);
   assign rsp.data = buf_ff[rd_ff];

   // configuration
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[3:2])
         sdspi_pkg::REG_WAKE:  csr_prdata = {24'd0, wake_ff};
         sdspi_pkg::REG_RESP:  csr_prdata = {24'd0, rlim_ff};
         sdspi_pkg::REG_RETRY: csr_prdata = {16'd0, ilim_ff};
         default:              csr_prdata = {24'd0, blim_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wake_ff <= 8'd10; rlim_ff <= 8'd8; ilim_ff <= 16'd2000; blim_ff <= 8'd200;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'd0) begin
         case (csr_paddr[3:2])
            sdspi_pkg::REG_WAKE:  wake_ff <= csr_pwdata[7:0];
            sdspi_pkg::REG_RESP:  rlim_ff <= csr_pwdata[7:0];
            sdspi_pkg::REG_RETRY: ilim_ff <= csr_pwdata[15:0];
            default:              blim_ff <= csr_pwdata[7:0];
         endcase
      end
   end

   // effective limits: zero acts as one
   logic [7:0]  wake_e, rlim_e, blim_e;
   logic [15:0] ilim_e;
   assign wake_e = (wake_ff == 8'd0) ? 8'd1 : wake_ff;
   assign rlim_e = (rlim_ff == 8'd0) ? 8'd1 : rlim_ff;
   assign blim_e = (blim_ff == 8'd0) ? 8'd1 : blim_ff;
   assign ilim_e = (ilim_ff == 16'd0) ? 16'd1 : ilim_ff;

   function automatic logic is_cmd(sdspi_pkg::phase_type p);
      return p == sdspi_pkg::PH_CMD0 || p == sdspi_pkg::PH_CMD8 ||
             p == sdspi_pkg::PH_CMD55 || p == sdspi_pkg::PH_ACMD41 ||
             p == sdspi_pkg::PH_CMD16 || p == sdspi_pkg::PH_CMD24;
   endfunction

   function automatic logic [7:0] frame_byte(sdspi_pkg::phase_type p, logic [2:0] i,
                                             logic [31:0] sec);
      logic [7:0]  code;
      logic [31:0] arg;
      logic [7:0]  crc;
      code = 8'h77; arg = 32'd0; crc = 8'hFF;
      case (p)
         sdspi_pkg::PH_CMD0:   begin code = 8'h40; crc = 8'h95; end
         sdspi_pkg::PH_CMD8:   begin code = 8'h48; arg = 32'h000001AA; crc = 8'h87; end
         sdspi_pkg::PH_ACMD41: begin code = 8'h69; arg = 32'h40000000; end
         sdspi_pkg::PH_CMD16:  begin code = 8'h50; arg = {22'd0, sdspi_pkg::BLOCK_BYTES}; end
         sdspi_pkg::PH_CMD24:  begin code = 8'h58; arg = sec; end
         default: ;
      endcase
      case (i)
         3'd0: return code;
         3'd1: return arg[31:24];
         3'd2: return arg[23:16];
         3'd3: return arg[15:8];
         3'd4: return arg[7:0];
         default: return crc;
      endcase
   endfunction

   // next state and result
   always_comb begin
      logic [7:0] pc;
      logic [15:0] rc;
      phase_in = phase_ff; fidx_in = fidx_ff; bcnt_in = bcnt_ff; poll_in = poll_ff;
      retry_in = retry_ff; last_in = last_ff; sector_in = sector_ff;
      r = '0; emit = 1'b0;
      pc = (poll_ff != 8'hFF) ? poll_ff + 8'd1 : poll_ff;
      rc = (retry_ff != 16'hFFFF) ? retry_ff + 16'd1 : retry_ff;
      case (q.command)
         sdspi_pkg::CMD_INIT: if (phase_ff == sdspi_pkg::PH_IDLE) begin
            phase_in = sdspi_pkg::PH_WAKE; poll_in = 8'd0;
            emit = 1'b1; r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE;
         end
         sdspi_pkg::CMD_WRITE: if (phase_ff == sdspi_pkg::PH_IDLE) begin
            sector_in = q.sector_address; phase_in = sdspi_pkg::PH_CMD24; fidx_in = 3'd0;
            emit = 1'b1; r.tx_valid = 1'b1; r.select_asserted = 1'b1; r.tx_byte = 8'h58;
         end
         sdspi_pkg::CMD_DATA: if (phase_ff == sdspi_pkg::PH_DATA_WAIT) begin
            phase_in = sdspi_pkg::PH_DATA_XFER;
            emit = 1'b1; r.tx_valid = 1'b1; r.select_asserted = 1'b1; r.tx_byte = q.data_value;
         end
         sdspi_pkg::CMD_TICK: if (phase_ff == sdspi_pkg::PH_BUSY_WAIT) begin
            emit = 1'b1; r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE;
            if (poll_ff >= blim_e) phase_in = sdspi_pkg::PH_FINAL_DUM;
            else begin phase_in = sdspi_pkg::PH_BUSY_XFER; r.select_asserted = 1'b1; end
         end
         sdspi_pkg::CMD_DONE: begin
            // default outcome: transfer of idle byte with select low
            r.tx_valid = 1'b1; r.tx_byte = sdspi_pkg::BYTE_IDLE; emit = 1'b1;
            if (is_cmd(phase_ff)) begin
               r.select_asserted = 1'b1;
               if (fidx_ff < 3'd5) begin
                  fidx_in = fidx_ff + 3'd1;
                  r.tx_byte = frame_byte(phase_ff, fidx_ff + 3'd1, sector_ff);
               end else if (fidx_ff == 3'd5) begin
                  fidx_in = sdspi_pkg::POLLING_R1; poll_in = 8'd0;
               end else begin
                  last_in = q.rx_byte; poll_in = pc;
                  if (!(q.rx_byte[7] && pc < rlim_e)) begin
                     // command complete
                     r.select_asserted = 1'b0;
                     case (phase_ff)
                        sdspi_pkg::PH_CMD0:  phase_in = sdspi_pkg::PH_CMD0_DUM;
                        sdspi_pkg::PH_CMD8:
                           if (q.rx_byte == 8'h01) begin
                              phase_in = sdspi_pkg::PH_CMD8_TRAIL; fidx_in = 3'd0;
                              r.select_asserted = 1'b1;
                           end else phase_in = sdspi_pkg::PH_CMD8_DUM;
                        sdspi_pkg::PH_CMD55:  phase_in = sdspi_pkg::PH_CMD55_DUM;
                        sdspi_pkg::PH_ACMD41: phase_in = sdspi_pkg::PH_ACMD41_DUM;
                        sdspi_pkg::PH_CMD16:  phase_in = sdspi_pkg::PH_CMD16_DUM;
                        default:
                           if (q.rx_byte != 8'h00) phase_in = sdspi_pkg::PH_CMD24_DUM;
                           else begin
                              phase_in = sdspi_pkg::PH_GAP; r.select_asserted = 1'b1;
                           end
                     endcase
                  end
               end
            end else begin
               case (phase_ff)
                  sdspi_pkg::PH_WAKE: begin
                     poll_in = pc;
                     if (pc >= wake_e) begin
                        phase_in = sdspi_pkg::PH_CMD0; fidx_in = 3'd0;
                        r.select_asserted = 1'b1; r.tx_byte = 8'h40;
                     end
                  end
                  sdspi_pkg::PH_CMD0_DUM:
                     if (last_ff != 8'h01) begin
                        phase_in = sdspi_pkg::PH_IDLE; r = '0; r.done_res = 1'b1;
                        r.status = sdspi_pkg::ST_NOT_IDLE;
                     end else begin
                        phase_in = sdspi_pkg::PH_CMD8; fidx_in = 3'd0;
                        r.select_asserted = 1'b1; r.tx_byte = 8'h48;
                     end
                  sdspi_pkg::PH_CMD8_TRAIL: begin
                     fidx_in = fidx_ff + 3'd1;
                     if (fidx_ff + 3'd1 < 3'd4) r.select_asserted = 1'b1;
                     else phase_in = sdspi_pkg::PH_CMD8_DUM;
                  end
                  sdspi_pkg::PH_CMD8_DUM: begin
                     retry_in = 16'd0; phase_in = sdspi_pkg::PH_CMD55; fidx_in = 3'd0;
                     r.select_asserted = 1'b1; r.tx_byte = 8'h77;
                  end
                  sdspi_pkg::PH_CMD55_DUM: begin
                     phase_in = sdspi_pkg::PH_ACMD41; fidx_in = 3'd0;
                     r.select_asserted = 1'b1; r.tx_byte = 8'h69;
                  end
                  sdspi_pkg::PH_ACMD41_DUM: begin
                     retry_in = rc; fidx_in = 3'd0; r.select_asserted = 1'b1;
                     if (last_ff == 8'h00) begin
                        phase_in = sdspi_pkg::PH_CMD16; r.tx_byte = 8'h50;
                     end else if (rc >= ilim_e) begin
                        phase_in = sdspi_pkg::PH_IDLE; fidx_in = fidx_ff; r = '0;
                        r.done_res = 1'b1; r.status = sdspi_pkg::ST_INIT_TO;
                     end else begin
                        phase_in = sdspi_pkg::PH_CMD55; r.tx_byte = 8'h77;
                     end
                  end
                  sdspi_pkg::PH_CMD16_DUM: begin
                     phase_in = sdspi_pkg::PH_IDLE; r = '0; r.done_res = 1'b1;
                     r.status = (last_ff == 8'h00) ? sdspi_pkg::ST_OK : sdspi_pkg::ST_BLEN_REJ;
                  end
                  sdspi_pkg::PH_CMD24_DUM: begin
                     phase_in = sdspi_pkg::PH_IDLE; r = '0; r.done_res = 1'b1;
                     r.status = sdspi_pkg::ST_CMD_REJ;
                  end
                  sdspi_pkg::PH_GAP: begin
                     phase_in = sdspi_pkg::PH_TOKEN; r.select_asserted = 1'b1;
                     r.tx_byte = sdspi_pkg::TOKEN;
                  end
                  sdspi_pkg::PH_TOKEN: begin
                     bcnt_in = 10'd0; phase_in = sdspi_pkg::PH_DATA_WAIT;
                     r = '0; r.data_request = 1'b1;
                  end
                  sdspi_pkg::PH_DATA_XFER: begin
                     bcnt_in = bcnt_ff + 10'd1;
                     if ({1'b0, bcnt_ff} + 11'd1 < {1'b0, sdspi_pkg::BLOCK_BYTES}) begin
                        phase_in = sdspi_pkg::PH_DATA_WAIT; r = '0; r.data_request = 1'b1;
                     end else begin
                        phase_in = sdspi_pkg::PH_CRC; fidx_in = 3'd0; r.select_asserted = 1'b1;
                     end
                  end
                  sdspi_pkg::PH_CRC: begin
                     fidx_in = fidx_ff + 3'd1; r.select_asserted = 1'b1;
                     if (fidx_ff + 3'd1 >= 3'd2) phase_in = sdspi_pkg::PH_RESP;
                  end
                  sdspi_pkg::PH_RESP: begin
                     last_in = q.rx_byte; phase_in = sdspi_pkg::PH_RESP_DUM;
                  end
                  sdspi_pkg::PH_RESP_DUM:
                     if (last_ff[4:0] != 5'h05) begin
                        phase_in = sdspi_pkg::PH_IDLE; r = '0; r.done_res = 1'b1;
                        r.status = sdspi_pkg::ST_DATA_REJ;
                     end else begin
                        poll_in = 8'd0; phase_in = sdspi_pkg::PH_BUSY_XFER;
                        r.select_asserted = 1'b1;
                     end
                  sdspi_pkg::PH_BUSY_XFER: begin
                     last_in = q.rx_byte; poll_in = pc;
                     if (q.rx_byte == 8'hFF) phase_in = sdspi_pkg::PH_FINAL_DUM;
                     else begin phase_in = sdspi_pkg::PH_BUSY_WAIT; emit = 1'b0; end
                  end
                  sdspi_pkg::PH_FINAL_DUM: begin
                     phase_in = sdspi_pkg::PH_IDLE; r = '0; r.done_res = 1'b1;
                     r.status = (last_ff == 8'hFF) ? sdspi_pkg::ST_OK : sdspi_pkg::ST_BUSY_TO;
                  end
                  default: emit = 1'b0;
               endcase
            end
         end
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdspi_pkg::PH_IDLE; fidx_ff <= 3'd0; bcnt_ff <= 10'd0;
         poll_ff <= 8'd0; retry_ff <= 16'd0; last_ff <= 8'hFF; sector_ff <= 32'd0;
      end else if (acc) begin
         phase_ff <= phase_in; fidx_ff <= fidx_in; bcnt_ff <= bcnt_in;
         poll_ff <= poll_in; retry_ff <= retry_in; last_ff <= last_in; sector_ff <= sector_in;
      end
   end

   // result buffer
   logic push, pop;
   assign push = acc && emit;
   assign pop = rsp.valid && rsp.ready;
   always_ff @(posedge clock) begin
      if (push) buf_ff[wr_ff] <= r;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

// ===== sv/sdspi_checker.sv =====
// port-level checker for the sd spi sequencer, bound to the top level
`default_nettype none
module sdspi_checker (
   input wire clock,
   input wire reset,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire sdspi_pkg::rsp_type rsp_data,
   input wire csr_pready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.tx_valid |-> rsp_data.tx_byte == 8'd0 &&
      !rsp_data.select_asserted) else $error("idle fields not zero");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.tx_valid && (rsp_data.done_res || rsp_data.data_request)))
      else $error("transfer mixed with done or request");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.status == sdspi_pkg::ST_OK)
      else $error("status without done");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind sd_spi_init_and_block_write sdspi_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_data(rsp.data), .csr_pready(csr_pready));
`default_nettype wire
